@@ rtl/ndp_pkg.sv @@
`timescale 1ns / 1ps

package ndp_pkg;

  // Field tags carried with every byte.
  localparam logic [2:0] TAG_HEADER  = 3'd0;
  localparam logic [2:0] TAG_TYPELEN = 3'd1;
  localparam logic [2:0] TAG_PAYLEN  = 3'd2;
  localparam logic [2:0] TAG_IDLEN   = 3'd3;
  localparam logic [2:0] TAG_TYPE    = 3'd4;
  localparam logic [2:0] TAG_ID      = 3'd5;
  localparam logic [2:0] TAG_PAYLOAD = 3'd6;
  localparam logic [2:0] TAG_IGNORED = 3'd7;

  // Record status codes reported on the last byte.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_PAYLEN_TR  = 3'd2;
  localparam logic [2:0] ST_IDLEN_TR   = 3'd3;
  localparam logic [2:0] ST_TYPE_TR    = 3'd4;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd5;
  localparam logic [2:0] ST_ID_TR      = 3'd6;
  localparam logic [2:0] ST_PAYLOAD_TR = 3'd7;

  localparam logic [2:0] MIN_BYTES = 3'd4;
  localparam logic [7:0] CTRL_MAX  = 8'd31;
  localparam logic [7:0] DEL_CODE  = 8'd127;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  field_tag;
    logic        record_done;
    logic [2:0]  status;
    logic [7:0]  header_flags;
    logic [7:0]  type_len;
    logic [7:0]  id_len;
    logic [31:0] payload_len;
  } result_t;

endpackage

@@ rtl/ndp_parse.sv @@
`timescale 1ns / 1ps

module ndp_parse import ndp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPELEN = 3'd1,
    PH_PAYLEN  = 3'd2,
    PH_IDLEN   = 3'd3,
    PH_TYPE    = 3'd4,
    PH_ID      = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] remaining;
  } walk_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bytes_seen_r, bytes_seen_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic [1:0]  len_idx_r, len_idx_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [7:0]  type_len_r, type_len_nxt;
  logic [7:0]  id_len_r, id_len_nxt;
  logic [31:0] pay_len_r, pay_len_nxt;
  logic        bad_char_r, bad_char_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [2:0]  status;
  walk_t       walk;

  function automatic walk_t enter_payload(input logic [31:0] plen);
    walk_t w;
    if (plen != 32'd0) begin
      w.phase     = PH_PAYLOAD;
      w.remaining = plen;
    end else begin
      w.phase     = PH_DONE;
      w.remaining = 32'd0;
    end
    return w;
  endfunction

  function automatic walk_t enter_id(input logic [7:0] ilen, input logic [31:0] plen);
    walk_t w;
    if (ilen != 8'd0) begin
      w.phase     = PH_ID;
      w.remaining = {24'd0, ilen};
    end else begin
      w = enter_payload(plen);
    end
    return w;
  endfunction

  function automatic walk_t enter_type(input logic [7:0] tlen, input logic [7:0] ilen,
                                       input logic [31:0] plen);
    walk_t w;
    if (tlen != 8'd0) begin
      w.phase     = PH_TYPE;
      w.remaining = {24'd0, tlen};
    end else begin
      w = enter_id(ilen, plen);
    end
    return w;
  endfunction

  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    len_idx_nxt    = len_idx_r;
    header_nxt     = header_r;
    type_len_nxt   = type_len_r;
    id_len_nxt     = id_len_r;
    pay_len_nxt    = pay_len_r;
    bad_char_nxt   = bad_char_r;
    err_nxt        = err_r;
    bytes_seen_nxt = bytes_seen_r;
    walk           = '{phase: PH_DONE, remaining: 32'd0};

    if (bytes_seen_r < MIN_BYTES) begin
      bytes_seen_nxt = bytes_seen_r + 3'd1;
    end

    unique case (phase_r)
      PH_HEADER: begin
        header_nxt = data_byte;
        phase_nxt  = PH_TYPELEN;
      end
      PH_TYPELEN: begin
        type_len_nxt = data_byte;
        pay_len_nxt  = 32'd0;
        len_idx_nxt  = 2'd0;
        phase_nxt    = PH_PAYLEN;
      end
      PH_PAYLEN: begin
        if (header_r[4]) begin
          pay_len_nxt = {24'd0, data_byte};
        end else begin
          pay_len_nxt = {pay_len_r[23:0], data_byte};
          len_idx_nxt = len_idx_r + 2'd1;
        end
        // The length is complete after one byte in a short record, else after four.
        if (header_r[4] || len_idx_r == 2'd3) begin
          if (header_r[3]) begin
            phase_nxt = PH_IDLEN;
          end else begin
            walk          = enter_type(type_len_r, id_len_r, pay_len_nxt);
            phase_nxt     = walk.phase;
            remaining_nxt = walk.remaining;
          end
        end
      end
      PH_IDLEN: begin
        id_len_nxt    = data_byte;
        walk          = enter_type(type_len_r, data_byte, pay_len_r);
        phase_nxt     = walk.phase;
        remaining_nxt = walk.remaining;
      end
      PH_TYPE: begin
        if (data_byte <= CTRL_MAX || data_byte == DEL_CODE) begin
          bad_char_nxt = 1'b1;
        end
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) begin
          if (bad_char_nxt) begin
            err_nxt   = ST_BAD_CHAR;
            phase_nxt = PH_DONE;
          end else begin
            walk          = enter_id(id_len_r, pay_len_r);
            phase_nxt     = walk.phase;
            remaining_nxt = walk.remaining;
          end
        end
      end
      PH_ID: begin
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) begin
          walk          = enter_payload(pay_len_r);
          phase_nxt     = walk.phase;
          remaining_nxt = walk.remaining;
        end
      end
      PH_PAYLOAD: begin
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_comb begin
    status = ST_OK;
    if (last_byte) begin
      if (bytes_seen_nxt < MIN_BYTES) begin
        status = ST_SHORT;
      end else begin
        unique case (phase_nxt)
          PH_PAYLEN:  status = ST_PAYLEN_TR;
          PH_IDLEN:   status = ST_IDLEN_TR;
          PH_TYPE:    status = ST_TYPE_TR;
          PH_ID:      status = ST_ID_TR;
          PH_PAYLOAD: status = ST_PAYLOAD_TR;
          PH_DONE:    status = err_nxt;
          default:    status = ST_SHORT;
        endcase
      end
    end
  end

  assign res.byte_out     = data_byte;
  assign res.field_tag    = phase_r;
  assign res.record_done  = last_byte;
  assign res.status       = status;
  assign res.header_flags = header_nxt;
  assign res.type_len     = type_len_nxt;
  assign res.id_len       = id_len_nxt;
  assign res.payload_len  = pay_len_nxt;

  // The last byte closes the record, so the next byte starts from reset state.
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_byte)) begin
      phase_r      <= PH_HEADER;
      bytes_seen_r <= 3'd0;
      remaining_r  <= 32'd0;
      len_idx_r    <= 2'd0;
      header_r     <= 8'd0;
      type_len_r   <= 8'd0;
      id_len_r     <= 8'd0;
      pay_len_r    <= 32'd0;
      bad_char_r   <= 1'b0;
      err_r        <= ST_OK;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      remaining_r  <= remaining_nxt;
      len_idx_r    <= len_idx_nxt;
      header_r     <= header_nxt;
      type_len_r   <= type_len_nxt;
      id_len_r     <= id_len_nxt;
      pay_len_r    <= pay_len_nxt;
      bad_char_r   <= bad_char_nxt;
      err_r        <= err_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_byte) |=> (phase_r == PH_HEADER && bytes_seen_r == 3'd0))
    else $error("parser did not restart after the last byte");

  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !res.record_done |-> (res.status == ST_OK))
    else $error("status reported without record end");

  a_bytes_sat: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= MIN_BYTES)
    else $error("byte count passed its saturation point");

endmodule

@@ rtl/ndp_queue.sv @@
`timescale 1ns / 1ps

module ndp_queue import ndp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t              mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("read from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/ndef_record_parser_top.sv @@
`timescale 1ns / 1ps
// A pushed byte's result is written into the queue at the push edge; if the queue was empty,
// it is then at the queue head and can be popped in the next cycle.
// Throughput: one byte per cycle while in_full is low, set by the parser state update.
// A result queue of QUEUE_DEPTH entries lets the parser keep going while the consumer stalls.
// Reset (synchronous, rst_n low) returns the parser to the header phase and empties the queue.

module ndef_record_parser_top import ndp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte_out,
  output logic [2:0]  out_field_tag,
  output logic        out_record_done,
  output logic [2:0]  out_status,
  output logic [7:0]  out_header_flags,
  output logic [7:0]  out_type_len,
  output logic [7:0]  out_id_len,
  output logic [31:0] out_payload_len
);

  logic    in_acc;
  logic    out_acc;
  result_t parse_res;
  result_t head;

  assign in_acc  = in_push && !in_full;
  assign out_acc = out_pop && !out_empty;

  ndp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res       (parse_res)
  );

  ndp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (parse_res),
    .rd_en   (out_acc),
    .rd_data (head),
    .full    (in_full),
    .empty   (out_empty)
  );

  assign out_byte_out     = head.byte_out;
  assign out_field_tag    = head.field_tag;
  assign out_record_done  = head.record_done;
  assign out_status       = head.status;
  assign out_header_flags = head.header_flags;
  assign out_type_len     = head.type_len;
  assign out_id_len       = head.id_len;
  assign out_payload_len  = head.payload_len;

endmodule
